// ===== rtl/stb_pkg.sv =====
package stb_pkg;

  // One 8-bit color or alpha channel.
  typedef logic [7:0] chan_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TINT_COLOR   = 2'd0,
    CFG_COLOR_SWAP   = 2'd1,
    CFG_REPLACE      = 2'd2,
    CFG_PREMULTIPLY  = 2'd3
  } cfg_idx_e;

  localparam logic [31:0] TINT_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] DIV_MUL    = 16'd32897;
  localparam int unsigned DIV_SHIFT  = 23;
  localparam logic [8:0]  CHAN_MAX   = 9'd255;

  // Divide by 255 as (x * 32897) >> 23; exact for x up to 255 * 255.
  function automatic chan_t div255(input logic [15:0] x);
    logic [31:0] prod;
    begin
      prod = 32'(x) * 32'(DIV_MUL);
      return prod[DIV_SHIFT+7:DIV_SHIFT];
    end
  endfunction

endpackage

// ===== rtl/stb_lane.sv =====
// One blend lane: two register stages from source, destination and alpha
// to the blended channel value.
module stb_lane import stb_pkg::*; (
  input  logic  clk_i,
  input  chan_t s_i,
  input  chan_t d_i,
  input  chan_t a_i,
  input  logic  premul_i,
  output chan_t res_o
);

  logic [15:0] prod_d, prod_q;
  chan_t       s_q;
  chan_t       inv;
  chan_t       quo;
  logic [8:0]  sum;
  chan_t       res_d, res_q;

  // First stage: the destination weight and the blend products, summed unless premultiplied.
  always_comb begin
    inv = 8'(CHAN_MAX) - a_i;
    if (premul_i) begin
      prod_d = 16'(d_i) * 16'(inv);
    end else begin
      prod_d = 16'(s_i) * 16'(a_i) + 16'(d_i) * 16'(inv);
    end
  end

  // Second stage: divide by 255, then add the source and clamp when premultiplied.
  always_comb begin
    quo = div255(prod_q);
    sum = 9'(s_q) + 9'(quo);
    if (premul_i) begin
      res_d = (sum > CHAN_MAX) ? 8'(CHAN_MAX) : sum[7:0];
    end else begin
      res_d = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    s_q    <= s_i;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/sprite_tint_alpha_blend.sv =====
// Sprite tint and alpha blend, one RGBA8888 pixel per transfer, R in the low byte.
//
// Input channel: a transfer happens at a clock edge where start_i is high and
// busy_o is low. busy_o is always low, so a new pixel can be started every cycle.
// Each transfer carries the sprite texel, the destination pixel and a bounds flag.
//
// Output channel: done_o is high for exactly one cycle with out_pixel_o, and the
// result transfer happens at the edge that ends that cycle. Results leave in
// start order, one per transfer. The receiver cannot stall; nothing is held back.
//
// Throughput is one pixel per clock. The pixel passes six register stages:
// input capture, tint products, tint divide, blend products, blend divide and
// clamp, and output select.
//
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// next edge and must be done while no pixel is in flight. Reset empties the
// pipeline, sets the tint to all ones (tinting off) and clears the mode bits.
module sprite_tint_alpha_blend import stb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] source_texel_i,
  input  logic [31:0] dest_pixel_i,
  input  logic        in_bounds_i,
  output logic        done_o,
  output logic [31:0] out_pixel_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned STAGES = 6;

  // Configuration registers.
  logic [31:0] tint_q;
  logic        white_q, replace_q, premul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q    <= TINT_RESET;
      white_q   <= 1'b0;
      replace_q <= 1'b0;
      premul_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TINT_COLOR:  tint_q    <= cfg_wdata_i;
        CFG_COLOR_SWAP:  white_q   <= cfg_wdata_i[0];
        CFG_REPLACE:     replace_q <= cfg_wdata_i[0];
        CFG_PREMULTIPLY: premul_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic tint_en;
  assign tint_en = (tint_q != TINT_RESET);

  // Valid bits travel alongside the pixel data.
  logic [STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[STAGES-1];

  // Stage 0: capture the pixel; an out-of-bounds texel reads as zero.
  chan_t       src0_q [4];
  logic [31:0] dst0_q;
  logic        act0_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      src0_q[c] <= in_bounds_i ? source_texel_i[8*c +: 8] : 8'd0;
    end
    dst0_q <= dest_pixel_i;
    act0_q <= in_bounds_i && (source_texel_i[31:24] != 8'd0);
  end

  // Stage 1: texel times tint, per channel.
  logic [15:0] tprod1_q [4];
  chan_t       src1_q [4];
  logic [31:0] dst1_q;
  logic        act1_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      tprod1_q[c] <= 16'(src0_q[c]) * 16'(tint_q[8*c +: 8]);
      src1_q[c]   <= src0_q[c];
    end
    dst1_q <= dst0_q;
    act1_q <= act0_q;
  end

  // Stage 2: tinted texel; white mask swaps in the tint colors for R, G and B while tinting is on.
  chan_t       tex2_d [4];
  chan_t       tex2_q [4];
  logic [31:0] dst2_q;
  logic        act2_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (!tint_en) begin
        tex2_d[c] = src1_q[c];
      end else if (white_q && c < 3) begin
        tex2_d[c] = tint_q[8*c +: 8];
      end else begin
        tex2_d[c] = div255(tprod1_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tex2_q <= tex2_d;
    dst2_q <= dst1_q;
    act2_q <= act1_q;
  end

  // Stages 3 and 4: blend lanes; alpha always adds like a premultiplied color.
  chan_t blend4 [4];

  for (genvar c = 0; c < 4; c++) begin : g_lane
    stb_lane u_lane (
      .clk_i    (clk_i),
      .s_i      (tex2_q[c]),
      .d_i      (dst2_q[8*c +: 8]),
      .a_i      (tex2_q[3]),
      .premul_i ((c == 3) ? 1'b1 : premul_q),
      .res_o    (blend4[c])
    );
  end

  // Delay the tinted texel and the destination to line up with the lanes.
  chan_t       tex3_q [4];
  chan_t       tex4_q [4];
  logic [31:0] dst3_q, dst4_q;
  logic        act3_q, act4_q;

  always_ff @(posedge clk_i) begin
    tex3_q <= tex2_q;
    tex4_q <= tex3_q;
    dst3_q <= dst2_q;
    dst4_q <= dst3_q;
    act3_q <= act2_q && (replace_q || (tex2_q[3] != 8'd0));
    act4_q <= act3_q;
  end

  // Stage 5: choose copy, blend or the untouched destination.
  logic [31:0] out_d, out_q;

  always_comb begin
    out_d = dst4_q;
    if (act4_q) begin
      for (int c = 0; c < 4; c++) begin
        out_d[8*c +: 8] = replace_q ? tex4_q[c] : blend4[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_pixel_o = out_q;

endmodule
